// ----- design/tick_nanosecond_converter_defines.svh -----
// Assertion macros for the tick/nanosecond converter.
`ifndef TICK_NANOSECOND_CONVERTER_DEFINES_SVH
`define TICK_NANOSECOND_CONVERTER_DEFINES_SVH
`ifndef SYNTHESIS
`define TNC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("tnc assertion failed");
`define TNC_NEVER(lbl, cond) `TNC_ASSERT(lbl, !(cond))
`else
`define TNC_ASSERT(lbl, prop)
`define TNC_NEVER(lbl, cond)
`endif
`endif

// ----- design/tnc_pkg.sv -----
// Shared constants and types of the tick/nanosecond converter.
`default_nettype none
package tnc_pkg;
    localparam int unsigned DIV_STAGES = 64;
    localparam logic [31:0] NS_PER_SEC = 32'd1000000000;
    localparam logic CMD_T2N = 1'b0;
    localparam logic CMD_N2T = 1'b1;

    typedef struct packed {
        logic        pass;
        logic [31:0] mul;
        logic [63:0] acc;
    } side_t;
endpackage
`default_nettype wire

// ----- design/tick_nanosecond_converter.sv -----
// Top level of the tick/nanosecond converter.
// Converts a 64-bit amount between counter ticks and nanoseconds at the
// configured counter frequency. Both directions share one datapath:
// result = (amount / d) * m + ((amount % d) * m) / d, with d = freq, m = 1e9
// for ticks to ns, and d = 1e9, m = freq for ns to ticks; all wraps mod 2^64.
// A zero frequency passes ticks through unchanged and turns ns into 0 ticks.
// One request is accepted every cycle unless a waiting result holds the pipe;
// each passes the two 64-stage bit-serial divider pipelines, the two multiply
// stages and the output register. The whole pipeline advances on one enable,
// so m_tready low with a result waiting holds every stage and s_tready.
// Configuration over cfg_valid/cfg_data is to be written only while idle; the block does not enforce this.
`default_nettype none
`include "tick_nanosecond_converter_defines.svh"
module tick_nanosecond_converter (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // config: counter_frequency_hz
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data,
    // request channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // [63:0] amount
    input  wire logic [0:0]  s_tuser,   // [0] cmd
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata    // [63:0] converted
);
    logic [31:0]    freq_reg;
    logic           en;
    logic [31:0]    d0;
    tnc_pkg::side_t side0;

    logic           v1;
    logic [63:0]    q1;
    logic [31:0]    r1;
    logic [31:0]    dd1;
    tnc_pkg::side_t s1;

    logic           vm;
    logic [63:0]    nm;
    logic [31:0]    dm;
    tnc_pkg::side_t sm;

    logic           v2;
    logic [63:0]    q2;
    logic [31:0]    r2;
    logic [31:0]    dd2;
    tnc_pkg::side_t s2;

    logic           out_valid_reg;
    logic [63:0]    out_data_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            freq_reg <= '0;
        end else if (cfg_valid) begin
            freq_reg <= cfg_data;
        end
    end

    // global advance: a waiting result freezes the whole pipe
    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    // pick divisor and multiplier per direction
    always_comb begin
        if (s_tuser[0] == tnc_pkg::CMD_N2T) begin
            d0        = tnc_pkg::NS_PER_SEC;
            side0.mul = freq_reg;
            side0.pass = 1'b0;
        end else begin
            d0        = freq_reg;
            side0.mul = tnc_pkg::NS_PER_SEC;
            side0.pass = (freq_reg == 32'd0);
        end
        side0.acc = s_tdata;
    end

    // amount -> whole, part
    tnc_div_pipe u_div_whole (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(s_tvalid), .in_num(s_tdata), .in_den(d0), .in_side(side0),
        .out_valid(v1), .out_quo(q1), .out_rem(r1), .out_den(dd1), .out_side(s1)
    );

    // part * m and whole * m
    tnc_mul_stage u_mul (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(v1), .in_quo(q1), .in_rem(r1), .in_den(dd1), .in_side(s1),
        .out_valid(vm), .out_num(nm), .out_den(dm), .out_side(sm)
    );

    // (part * m) / d; remainder unused
    tnc_div_pipe u_div_part (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(vm), .in_num(nm), .in_den(dm), .in_side(sm),
        .out_valid(v2), .out_quo(q2), .out_rem(r2), .out_den(dd2), .out_side(s2)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= v2;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_data_reg <= s2.pass ? s2.acc : (s2.acc + q2);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `TNC_NEVER(a_stall_blocks_input, m_tvalid && !m_tready && s_tready)
    `TNC_ASSERT(a_result_after_advance, $rose(m_tvalid) |-> $past(s_tready))
    `TNC_ASSERT(a_freq_only_on_write, !$past(cfg_valid) |-> $stable(freq_reg))
    `TNC_NEVER(a_pass_only_t2n, v2 && s2.pass && (s2.mul != tnc_pkg::NS_PER_SEC))
endmodule
`default_nettype wire

// ----- design/tnc_div_pipe.sv -----
// Pipelined restoring divider, 64-bit dividend by 32-bit divisor, one bit per stage.
`default_nettype none
module tnc_div_pipe (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           en,
    input  wire logic           in_valid,
    input  wire logic [63:0]    in_num,
    input  wire logic [31:0]    in_den,
    input  wire tnc_pkg::side_t in_side,
    output logic                out_valid,
    output logic [63:0]         out_quo,
    output logic [31:0]         out_rem,
    output logic [31:0]         out_den,
    output tnc_pkg::side_t      out_side
);
    logic           v_reg    [tnc_pkg::DIV_STAGES];
    logic [31:0]    r_reg    [tnc_pkg::DIV_STAGES];
    logic [63:0]    n_reg    [tnc_pkg::DIV_STAGES];
    logic [31:0]    d_reg    [tnc_pkg::DIV_STAGES];
    tnc_pkg::side_t side_reg [tnc_pkg::DIV_STAGES];

    for (genvar i = 0; i < tnc_pkg::DIV_STAGES; i++) begin : g_stage
        logic           v_in;
        logic [31:0]    r_in;
        logic [63:0]    n_in;
        logic [31:0]    d_in;
        tnc_pkg::side_t s_in;
        logic [32:0]    trial;
        logic [32:0]    diff;
        logic           qbit;

        if (i == 0) begin : g_first
            assign v_in = in_valid;
            assign r_in = '0;
            assign n_in = in_num;
            assign d_in = in_den;
            assign s_in = in_side;
        end else begin : g_rest
            assign v_in = v_reg[i-1];
            assign r_in = r_reg[i-1];
            assign n_in = n_reg[i-1];
            assign d_in = d_reg[i-1];
            assign s_in = side_reg[i-1];
        end

        // shift in next dividend bit, subtract if it fits
        assign trial = {r_in, n_in[63]};
        assign diff  = trial - {1'b0, d_in};
        assign qbit  = (trial >= {1'b0, d_in});

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i] <= 1'b0;
            end else if (en) begin
                v_reg[i] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[i]    <= qbit ? diff[31:0] : trial[31:0];
                n_reg[i]    <= {n_in[62:0], qbit};
                d_reg[i]    <= d_in;
                side_reg[i] <= s_in;
            end
        end
    end

    assign out_valid = v_reg[tnc_pkg::DIV_STAGES-1];
    assign out_quo   = n_reg[tnc_pkg::DIV_STAGES-1];
    assign out_rem   = r_reg[tnc_pkg::DIV_STAGES-1];
    assign out_den   = d_reg[tnc_pkg::DIV_STAGES-1];
    assign out_side  = side_reg[tnc_pkg::DIV_STAGES-1];
endmodule
`default_nettype wire

// ----- design/tnc_mul_stage.sv -----
// Two-stage multiply: remainder product and wrapped whole-second product.
`default_nettype none
module tnc_mul_stage (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           en,
    input  wire logic           in_valid,
    input  wire logic [63:0]    in_quo,
    input  wire logic [31:0]    in_rem,
    input  wire logic [31:0]    in_den,
    input  wire tnc_pkg::side_t in_side,
    output logic                out_valid,
    output logic [63:0]         out_num,
    output logic [31:0]         out_den,
    output tnc_pkg::side_t      out_side
);
    logic           v1_reg;
    logic [63:0]    pm_reg;
    logic [63:0]    lo_reg;
    logic [63:0]    hi_reg;
    logic [31:0]    d1_reg;
    tnc_pkg::side_t s1_reg;
    logic           v2_reg;
    logic [63:0]    num_reg;
    logic [31:0]    d2_reg;
    tnc_pkg::side_t s2_reg;
    tnc_pkg::side_t s2_next;

    always_comb begin
        s2_next     = s1_reg;
        // whole * mul mod 2^64 from two 32x32 partial products
        s2_next.acc = s1_reg.pass ? s1_reg.acc : (lo_reg + {hi_reg[31:0], 32'd0});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pm_reg  <= 64'(in_rem) * 64'(in_side.mul);
            lo_reg  <= 64'(in_quo[31:0]) * 64'(in_side.mul);
            hi_reg  <= 64'(in_quo[63:32]) * 64'(in_side.mul);
            d1_reg  <= in_den;
            s1_reg  <= in_side;
            num_reg <= pm_reg;
            d2_reg  <= d1_reg;
            s2_reg  <= s2_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_num   = num_reg;
    assign out_den   = d2_reg;
    assign out_side  = s2_reg;
endmodule
`default_nettype wire
